>>> sv/ddpwm_pkg.sv
package ddpwm_pkg;

  localparam int DEF_COUNT_WIDTH = 8;
  localparam int SPEED_W         = 8;

  // event kinds carried in tuser
  localparam logic [1:0] MODE_CMD   = 2'd0;
  localparam logic [1:0] MODE_PWM   = 2'd1;
  localparam logic [1:0] MODE_BLINK = 2'd2;

  // ASCII command characters
  localparam logic [7:0] CMD_FWD     = 8'h66; // f
  localparam logic [7:0] CMD_BACK    = 8'h62; // b
  localparam logic [7:0] CMD_STOP    = 8'h73; // s
  localparam logic [7:0] CMD_PIVOT_L = 8'h6c; // l
  localparam logic [7:0] CMD_PIVOT_R = 8'h72; // r
  localparam logic [7:0] CMD_WIDE_L  = 8'h71; // q
  localparam logic [7:0] CMD_WIDE_R  = 8'h65; // e
  localparam logic [7:0] CMD_SHARP_L = 8'h7a; // z
  localparam logic [7:0] CMD_SHARP_R = 8'h63; // c

  localparam logic [1:0] SIG_OFF   = 2'd0;
  localparam logic [1:0] SIG_LEFT  = 2'd1;
  localparam logic [1:0] SIG_RIGHT = 2'd2;

  localparam logic [1:0] REG_SPEED_HIGH = 2'd0;
  localparam logic [1:0] REG_SPEED_MID  = 2'd1;
  localparam logic [1:0] REG_SPEED_LOW  = 2'd2;

  localparam logic [SPEED_W-1:0] SPEED_HIGH_RST = 8'd150;
  localparam logic [SPEED_W-1:0] SPEED_MID_RST  = 8'd100;
  localparam logic [SPEED_W-1:0] SPEED_LOW_RST  = 8'd50;

  typedef struct packed {
    logic               we;
    logic [1:0]         addr;
    logic [SPEED_W-1:0] data;
  } cfg_wr_t;

  // packs straight into out_tdata[5:0]
  typedef struct packed {
    logic [1:0] led_word;
    logic       dir_left;
    logic       pwm_left;
    logic       dir_right;
    logic       pwm_right;
  } res_t;

endpackage

>>> sv/ddpwm_core.sv
module ddpwm_core import ddpwm_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_wr_t    cfg,
  input  logic       accept,
  input  logic [1:0] mode,
  input  logic [7:0] cmd_byte,
  output res_t       res_nxt
);

  localparam int CMP_W = (COUNT_WIDTH > SPEED_W) ? COUNT_WIDTH : SPEED_W;

  logic [SPEED_W-1:0]     speed_high_r, speed_mid_r, speed_low_r;
  logic [COUNT_WIDTH-1:0] duty_count_r, duty_count_nxt;
  logic [SPEED_W-1:0]     right_speed_r, right_speed_nxt;
  logic [SPEED_W-1:0]     left_speed_r, left_speed_nxt;
  logic                   right_fwd_r, right_fwd_nxt;
  logic                   left_fwd_r, left_fwd_nxt;
  logic [1:0]             sig_mode_r, sig_mode_nxt;
  logic                   blink_r, blink_nxt;
  logic [3:0]             motor_r, motor_nxt;
  logic [1:0]             led_r, led_nxt;
  logic [CMP_W-1:0]       cnt_ext, rs_ext, ls_ext;

  assign cnt_ext = CMP_W'(duty_count_nxt);
  assign rs_ext  = CMP_W'(right_speed_r);
  assign ls_ext  = CMP_W'(left_speed_r);

  always_comb begin
    duty_count_nxt  = duty_count_r;
    right_speed_nxt = right_speed_r;
    left_speed_nxt  = left_speed_r;
    right_fwd_nxt   = right_fwd_r;
    left_fwd_nxt    = left_fwd_r;
    sig_mode_nxt    = sig_mode_r;
    blink_nxt       = blink_r;
    motor_nxt       = motor_r;
    led_nxt         = led_r;
    unique case (mode)
      MODE_CMD: begin
        unique case (cmd_byte)
          CMD_FWD: begin
            {right_fwd_nxt, left_fwd_nxt} = 2'b11;
            right_speed_nxt = speed_high_r;
            left_speed_nxt  = speed_high_r;
            sig_mode_nxt    = SIG_OFF;
            led_nxt         = 2'b00;
          end
          CMD_BACK: begin
            {right_fwd_nxt, left_fwd_nxt} = 2'b00;
            right_speed_nxt = speed_high_r;
            left_speed_nxt  = speed_high_r;
            sig_mode_nxt    = SIG_OFF;
            led_nxt         = 2'b00;
          end
          CMD_STOP: begin
            {right_fwd_nxt, left_fwd_nxt} = 2'b00;
            right_speed_nxt = '0;
            left_speed_nxt  = '0;
            sig_mode_nxt    = SIG_OFF;
            led_nxt         = 2'b00;
          end
          CMD_PIVOT_L: begin
            {right_fwd_nxt, left_fwd_nxt} = 2'b10;
            right_speed_nxt = speed_high_r;
            left_speed_nxt  = speed_high_r;
            sig_mode_nxt    = SIG_LEFT;
          end
          CMD_PIVOT_R: begin
            {right_fwd_nxt, left_fwd_nxt} = 2'b01;
            right_speed_nxt = speed_high_r;
            left_speed_nxt  = speed_high_r;
            sig_mode_nxt    = SIG_RIGHT;
          end
          CMD_WIDE_L: begin
            {right_fwd_nxt, left_fwd_nxt} = 2'b11;
            right_speed_nxt = speed_high_r;
            left_speed_nxt  = speed_mid_r;
            sig_mode_nxt    = SIG_LEFT;
          end
          CMD_WIDE_R: begin
            {right_fwd_nxt, left_fwd_nxt} = 2'b11;
            right_speed_nxt = speed_mid_r;
            left_speed_nxt  = speed_high_r;
            sig_mode_nxt    = SIG_RIGHT;
          end
          CMD_SHARP_L: begin
            {right_fwd_nxt, left_fwd_nxt} = 2'b11;
            right_speed_nxt = speed_high_r;
            left_speed_nxt  = speed_low_r;
            sig_mode_nxt    = SIG_LEFT;
          end
          CMD_SHARP_R: begin
            {right_fwd_nxt, left_fwd_nxt} = 2'b11;
            right_speed_nxt = speed_low_r;
            left_speed_nxt  = speed_high_r;
            sig_mode_nxt    = SIG_RIGHT;
          end
          default: ; // unknown byte, nothing moves
        endcase
      end
      MODE_PWM: begin
        duty_count_nxt = duty_count_r + COUNT_WIDTH'(1);
        // compare against the advanced count
        motor_nxt = {left_fwd_r, (cnt_ext < ls_ext), right_fwd_r, (cnt_ext < rs_ext)};
      end
      MODE_BLINK: begin
        blink_nxt = ~blink_r;
        unique case (sig_mode_r)
          SIG_LEFT:  led_nxt = {1'b0, ~blink_r};
          SIG_RIGHT: led_nxt = {~blink_r, 1'b0};
          default:   led_nxt = 2'b00;
        endcase
      end
      default: ; // no event
    endcase
  end

  assign res_nxt = '{led_word:  led_nxt,
                     dir_left:  motor_nxt[3],
                     pwm_left:  motor_nxt[2],
                     dir_right: motor_nxt[1],
                     pwm_right: motor_nxt[0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_high_r  <= SPEED_HIGH_RST;
      speed_mid_r   <= SPEED_MID_RST;
      speed_low_r   <= SPEED_LOW_RST;
      duty_count_r  <= '0;
      right_speed_r <= '0;
      left_speed_r  <= '0;
      right_fwd_r   <= 1'b0;
      left_fwd_r    <= 1'b0;
      sig_mode_r    <= SIG_OFF;
      blink_r       <= 1'b0;
      motor_r       <= '0;
      led_r         <= '0;
    end else begin
      if (cfg.we) begin
        unique case (cfg.addr)
          REG_SPEED_HIGH: speed_high_r <= cfg.data;
          REG_SPEED_MID:  speed_mid_r  <= cfg.data;
          REG_SPEED_LOW:  speed_low_r  <= cfg.data;
          default: ;
        endcase
      end
      if (accept) begin
        duty_count_r  <= duty_count_nxt;
        right_speed_r <= right_speed_nxt;
        left_speed_r  <= left_speed_nxt;
        right_fwd_r   <= right_fwd_nxt;
        left_fwd_r    <= left_fwd_nxt;
        sig_mode_r    <= sig_mode_nxt;
        blink_r       <= blink_nxt;
        motor_r       <= motor_nxt;
        led_r         <= led_nxt;
      end
    end
  end

endmodule

>>> sv/ddpwm_obuf.sv
module ddpwm_obuf import ddpwm_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic not_full,
  output logic pop_valid,
  input  logic pop_ready,
  output res_t pop_data
);

  res_t       slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;
  logic       pop;

  assign not_full  = (count_r != 2'd2);
  assign pop_valid = (count_r != 2'd0);
  assign pop_data  = slot_r[rd_ptr_r];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      if (push && !pop)      count_r <= count_r + 2'd1;
      else if (pop && !push) count_r <= count_r - 2'd1;
    end
  end

endmodule

>>> sv/differential_drive_pwm_controller_top.sv
// channel | dir | beat moves                          | handshake
// in_     | in  | tuser: mode, tdata: cmd_byte        | in_tvalid / in_tready
// out_    | out | tdata: motor bits, led_word         | out_tvalid / out_tready
// cfg_    | in  | register index and value            | cfg_we, no wait
//
// Every accepted input beat yields one result beat; one beat per cycle sustained
// while out_tready is high. The event is applied to the drive state in the accept
// cycle and the result is registered into a two-entry output buffer.
// in_tready decodes the registered buffer fill count and drops only when both
// slots hold unread results, so a single stalled result does not stop the input.
// Reset is synchronous on rst_n and restores the speed registers to defaults.
module differential_drive_pwm_controller_top import ddpwm_pkg::*; #(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] cmd_byte
  input  logic [1:0] in_tuser,   // [1:0] mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [0] pwm_right, [1] dir_right, [2] pwm_left,
                                 // [3] dir_left, [5:4] led_word, [7:6] zero
  input  logic       cfg_we,
  input  logic [1:0] cfg_addr,
  input  logic [7:0] cfg_wdata
);

  logic    in_accept;
  res_t    res_nxt, res_out;
  cfg_wr_t cfg;

  assign in_accept = in_tvalid && in_tready;
  assign cfg       = '{we: cfg_we, addr: cfg_addr, data: cfg_wdata};

  ddpwm_core #(.COUNT_WIDTH(COUNT_WIDTH)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .accept   (in_accept),
    .mode     (in_tuser),
    .cmd_byte (in_tdata),
    .res_nxt  (res_nxt)
  );

  ddpwm_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept),
    .push_data (res_nxt),
    .not_full  (in_tready),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (res_out)
  );

  assign out_tdata = {2'b00, res_out};

  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output buffer not empty after reset");

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_tvalid)
    else $error("accepted beat left no result");

  a_full_means_pending: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input held off with no result pending");

endmodule

>>> test/differential_drive_pwm_controller_top_tb.sv
module differential_drive_pwm_controller_top_tb;
  import ddpwm_pkg::*;

  localparam logic [1:0] MODE_NONE = 2'd3;  // no event, outputs only
  localparam int         STALL_LIMIT = 1000;

  // Drive state predictor plus the queue of motor/LED words still owed by the block.
  class drive_scoreboard;
    logic [SPEED_W-1:0]         spd_high, spd_mid, spd_low;
    logic [DEF_COUNT_WIDTH-1:0] duty;
    logic [SPEED_W-1:0]         r_spd, l_spd;
    logic                       r_fwd, l_fwd;
    logic [1:0]                 sig;
    logic                       phase;
    res_t                       word;
    res_t                       owed_words[$];
    int                         mismatches;

    function new();
      spd_high = SPEED_HIGH_RST;
      spd_mid  = SPEED_MID_RST;
      spd_low  = SPEED_LOW_RST;
      duty     = '0;
      r_spd    = '0;
      l_spd    = '0;
      r_fwd    = 1'b0;
      l_fwd    = 1'b0;
      sig      = SIG_OFF;
      phase    = 1'b0;
      word     = '0;
      mismatches = 0;
    endfunction

    function void set_speed(logic [1:0] idx, logic [SPEED_W-1:0] v);
      case (idx)
        REG_SPEED_HIGH: spd_high = v;
        REG_SPEED_MID:  spd_mid  = v;
        REG_SPEED_LOW:  spd_low  = v;
        default: ;
      endcase
    endfunction

    function void set_drive(logic rf, logic lf, logic [SPEED_W-1:0] rs,
                            logic [SPEED_W-1:0] ls, logic [1:0] s);
      r_fwd = rf;
      l_fwd = lf;
      r_spd = rs;
      l_spd = ls;
      sig   = s;
    endfunction

    function void note_event(logic [1:0] mode, logic [7:0] cmd);
      case (mode)
        MODE_CMD: begin
          case (cmd)
            CMD_FWD: begin
              set_drive(1'b1, 1'b1, spd_high, spd_high, SIG_OFF);
              word.led_word = 2'b00;
            end
            CMD_BACK: begin
              set_drive(1'b0, 1'b0, spd_high, spd_high, SIG_OFF);
              word.led_word = 2'b00;
            end
            CMD_STOP: begin
              set_drive(1'b0, 1'b0, '0, '0, SIG_OFF);
              word.led_word = 2'b00;
            end
            // turns leave the LEDs alone until the next blink
            CMD_PIVOT_L: set_drive(1'b1, 1'b0, spd_high, spd_high, SIG_LEFT);
            CMD_PIVOT_R: set_drive(1'b0, 1'b1, spd_high, spd_high, SIG_RIGHT);
            CMD_WIDE_L:  set_drive(1'b1, 1'b1, spd_high, spd_mid, SIG_LEFT);
            CMD_WIDE_R:  set_drive(1'b1, 1'b1, spd_mid, spd_high, SIG_RIGHT);
            CMD_SHARP_L: set_drive(1'b1, 1'b1, spd_high, spd_low, SIG_LEFT);
            CMD_SHARP_R: set_drive(1'b1, 1'b1, spd_low, spd_high, SIG_RIGHT);
            default: ;
          endcase
        end
        MODE_PWM: begin
          duty = duty + 1'b1;
          word.pwm_right = (duty < r_spd);
          word.dir_right = r_fwd;
          word.pwm_left  = (duty < l_spd);
          word.dir_left  = l_fwd;
        end
        MODE_BLINK: begin
          phase = ~phase;
          case (sig)
            SIG_LEFT:  word.led_word = {1'b0, phase};
            SIG_RIGHT: word.led_word = {phase, 1'b0};
            default:   word.led_word = 2'b00;
          endcase
        end
        default: ;
      endcase
      owed_words.push_back(word);
    endfunction

    task flag_mismatch(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_word(logic [7:0] data);
      res_t got, want;
      got = res_t'(data[5:0]);
      if (owed_words.size() == 0) begin
        flag_mismatch($sformatf("result beat 0x%02h with nothing outstanding", data));
      end else begin
        want = owed_words.pop_front();
        if (got.pwm_right !== want.pwm_right)
          flag_mismatch($sformatf("pwm_right %b, want %b", got.pwm_right, want.pwm_right));
        if (got.dir_right !== want.dir_right)
          flag_mismatch($sformatf("dir_right %b, want %b", got.dir_right, want.dir_right));
        if (got.pwm_left !== want.pwm_left)
          flag_mismatch($sformatf("pwm_left %b, want %b", got.pwm_left, want.pwm_left));
        if (got.dir_left !== want.dir_left)
          flag_mismatch($sformatf("dir_left %b, want %b", got.dir_left, want.dir_left));
        if (got.led_word !== want.led_word)
          flag_mismatch($sformatf("led_word %b, want %b", got.led_word, want.led_word));
      end
    endtask
  endclass

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // [7:0] cmd_byte
  logic [1:0] in_tuser;   // [1:0] mode
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // [0] pwm_right, [1] dir_right, [2] pwm_left,
                          // [3] dir_left, [5:4] led_word, [7:6] zero
  logic       cfg_we;
  logic [1:0] cfg_addr;
  logic [7:0] cfg_wdata;

  drive_scoreboard sb;
  int              in_idle_pct;
  int              out_stall_pct;
  int              quiet_cycles;

  logic [7:0] drive_cmds [9] = '{CMD_FWD, CMD_BACK, CMD_STOP, CMD_PIVOT_L, CMD_PIVOT_R,
                                 CMD_WIDE_L, CMD_WIDE_R, CMD_SHARP_L, CMD_SHARP_R};

  // {mode, cmd_byte} pairs for the opening directed run
  logic [9:0] directed_beats [22] = '{
    {MODE_PWM, 8'h00},      {MODE_CMD, CMD_FWD},     {MODE_PWM, 8'hff},
    {MODE_BLINK, 8'h00},    {MODE_CMD, CMD_PIVOT_L}, {MODE_BLINK, 8'hff},
    {MODE_BLINK, 8'h00},    {MODE_CMD, CMD_PIVOT_R}, {MODE_PWM, 8'h00},
    {MODE_BLINK, 8'h00},    {MODE_CMD, CMD_WIDE_L},  {MODE_CMD, CMD_WIDE_R},
    {MODE_CMD, CMD_SHARP_L}, {MODE_PWM, 8'h00},      {MODE_CMD, CMD_SHARP_R},
    {MODE_BLINK, 8'h00},    {MODE_CMD, CMD_BACK},    {MODE_CMD, 8'h00},
    {MODE_CMD, 8'hff},      {MODE_NONE, 8'hff},      {MODE_CMD, CMD_STOP},
    {MODE_PWM, 8'h00}
  };

  differential_drive_pwm_controller_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= out_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_event(in_tuser, in_tdata);
      if (out_tvalid && out_tready) sb.check_word(out_tdata);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  // called and returns at a falling edge
  task automatic send_beat(logic [1:0] mode, logic [7:0] cmd);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = cmd;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_speed(logic [1:0] idx, logic [7:0] v);
    cfg_we    = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = v;
    @(posedge clk);
    sb.set_speed(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    in_tvalid = 1'b0;
    while (sb.owed_words.size() != 0) @(negedge clk);
  endtask

  task automatic random_beat();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 55)
      send_beat(MODE_PWM, 8'($urandom));
    else if (pick < 72)
      send_beat(MODE_CMD, drive_cmds[$urandom_range(0, 8)]);
    else if (pick < 87)
      send_beat(MODE_BLINK, 8'($urandom));
    else if (pick < 94)
      send_beat(MODE_CMD, 8'($urandom));  // mostly unknown bytes
    else
      send_beat(MODE_NONE, 8'($urandom));
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = MODE_CMD;
    out_tready    = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_SPEED_HIGH;
    cfg_wdata     = '0;
    in_idle_pct   = 0;
    out_stall_pct = 0;
    quiet_cycles  = 0;
    sb = new();
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_beats[i]) send_beat(directed_beats[i][9:8], directed_beats[i][7:0]);

    // speed extremes: mid 0 keeps the inner wheel off, low 1 only on count 0
    wait_drained();
    write_speed(REG_SPEED_HIGH, 8'd255);
    write_speed(REG_SPEED_MID, 8'd0);
    write_speed(REG_SPEED_LOW, 8'd1);
    send_beat(MODE_CMD, CMD_WIDE_L);
    send_beat(MODE_PWM, 8'h00);
    send_beat(MODE_CMD, CMD_SHARP_R);

    for (int blk = 0; blk < 8; blk++) begin
      wait_drained();
      case (blk)
        0: begin
          write_speed(REG_SPEED_HIGH, 8'd0);
          write_speed(REG_SPEED_MID, 8'd255);
          write_speed(REG_SPEED_LOW, 8'd255);
        end
        1: begin
          write_speed(REG_SPEED_HIGH, 8'd255);
          write_speed(REG_SPEED_MID, 8'd128);
          write_speed(REG_SPEED_LOW, 8'd0);
        end
        default: begin
          write_speed(REG_SPEED_HIGH, 8'($urandom_range(0, 255)));
          write_speed(REG_SPEED_MID, 8'($urandom_range(0, 255)));
          write_speed(REG_SPEED_LOW, 8'($urandom_range(0, 255)));
        end
      endcase
      case (blk / 2)
        0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
        1: begin in_idle_pct = 78; out_stall_pct = 0;  end
        2: begin in_idle_pct = 0;  out_stall_pct = 78; end
        default: begin in_idle_pct = 27; out_stall_pct = 27; end
      endcase
      repeat (103) random_beat();
    end

    wait_drained();
    repeat (8) @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
